>>> hw/rtl/grev_pkg.sv
// Shared types, codes and defaults of the grid region envelope tracer.
`default_nettype none

package grev_pkg;

    // Default sizes of the stores.
    localparam int DEF_MAX_COLUMNS = 64;
    localparam int DEF_MAX_ROWS    = 64;
    localparam int DEF_MAX_POINTS  = 512;
    localparam int DEF_LABEL_BITS  = 8;

    // Fixed field widths of the beats.
    localparam int COORD_W   = 7;
    localparam int LABEL_W   = 8;
    localparam int IDX_W     = 10;
    localparam int CNT_OUT_W = 10;
    localparam int MODE_W    = 2;

    // Grid size registers come out of reset at this value, then clamped.
    localparam int GRID_RESET = 64;

    // Request kinds carried in the slave tuser.
    localparam logic [MODE_W-1:0] MODE_LOAD  = 2'd0;
    localparam logic [MODE_W-1:0] MODE_TRACE = 2'd1;
    localparam logic [MODE_W-1:0] MODE_READ  = 2'd2;

    // Register indexes on the configuration port.
    localparam logic REG_GRID_COLUMNS = 1'b0;
    localparam logic REG_GRID_ROWS    = 1'b1;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_READ,
        ST_PASS,
        ST_SCAN,
        ST_DRAIN,
        ST_EMIT0,
        ST_EMIT1,
        ST_DONE
    } t_state;

    typedef enum logic [1:0] {
        PASS_NORTH,
        PASS_EAST,
        PASS_SOUTH,
        PASS_WEST
    } t_pass;

endpackage

`default_nettype wire

>>> hw/rtl/grev_cfg_regs.sv
// Configuration registers of the tracer: grid columns and rows, with clamping.
`default_nettype none

module grev_cfg_regs
    import grev_pkg::*;
#(
    parameter int MAX_COLUMNS = DEF_MAX_COLUMNS,
    parameter int MAX_ROWS    = DEF_MAX_ROWS
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               psel,
    input  wire logic               penable,
    input  wire logic               pwrite,
    input  wire logic [2:0]         paddr,
    input  wire logic [31:0]        pwdata,
    output logic      [31:0]        prdata,
    output logic                    pready,
    output logic      [COORD_W-1:0] o_grid_columns,
    output logic      [COORD_W-1:0] o_grid_rows
);

    localparam int RST_COLS = (GRID_RESET > MAX_COLUMNS) ? MAX_COLUMNS : GRID_RESET;
    localparam int RST_ROWS = (GRID_RESET > MAX_ROWS) ? MAX_ROWS : GRID_RESET;

    logic [COORD_W-1:0] r_cols;
    logic [COORD_W-1:0] r_rows;
    logic [COORD_W-1:0] wr_raw;
    logic [COORD_W-1:0] wr_cols;
    logic [COORD_W-1:0] wr_rows;
    logic               wr_en;
    logic               sel;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite && pready;
    // Byte lane bits paddr[1:0] do not take part in the decode.
    assign sel    = paddr[2];
    assign wr_raw = pwdata[COORD_W-1:0];

    // Zero acts as one, anything above the store size acts as the size.
    always_comb begin
        wr_cols = wr_raw;
        if (wr_raw == '0) begin
            wr_cols = COORD_W'(1);
        end else if (32'(wr_raw) > 32'(MAX_COLUMNS)) begin
            wr_cols = COORD_W'(MAX_COLUMNS);
        end
        wr_rows = wr_raw;
        if (wr_raw == '0) begin
            wr_rows = COORD_W'(1);
        end else if (32'(wr_raw) > 32'(MAX_ROWS)) begin
            wr_rows = COORD_W'(MAX_ROWS);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cols <= COORD_W'(RST_COLS);
            r_rows <= COORD_W'(RST_ROWS);
        end else if (wr_en) begin
            unique case (sel)
                REG_GRID_COLUMNS: r_cols <= wr_cols;
                REG_GRID_ROWS:    r_rows <= wr_rows;
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (sel)
            REG_GRID_COLUMNS: prdata = {{(32-COORD_W){1'b0}}, r_cols};
            REG_GRID_ROWS:    prdata = {{(32-COORD_W){1'b0}}, r_rows};
            default:          prdata = '0;
        endcase
    end

    assign o_grid_columns = r_cols;
    assign o_grid_rows    = r_rows;

endmodule

`default_nettype wire

>>> hw/rtl/grev_grid_mem.sv
// Label grid memory: one write port, one registered read port.
`default_nettype none

module grev_grid_mem
    import grev_pkg::*;
#(
    parameter int MAX_COLUMNS = DEF_MAX_COLUMNS,
    parameter int MAX_ROWS    = DEF_MAX_ROWS,
    parameter int LABEL_BITS  = DEF_LABEL_BITS
) (
    input  wire logic                                      i_clk,
    input  wire logic                                      i_we,
    input  wire logic [$clog2(MAX_COLUMNS*MAX_ROWS)-1:0]   i_waddr,
    input  wire logic [LABEL_BITS-1:0]                     i_wdata,
    input  wire logic [$clog2(MAX_COLUMNS*MAX_ROWS)-1:0]   i_raddr,
    output logic      [LABEL_BITS-1:0]                     o_rdata
);

    localparam int DEPTH = MAX_COLUMNS * MAX_ROWS;

    logic [LABEL_BITS-1:0] mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        o_rdata <= mem[i_raddr];
    end

endmodule

`default_nettype wire

>>> hw/rtl/grev_vtx_mem.sv
// Vertex store: x and y corner coordinates side by side, registered read.
`default_nettype none

module grev_vtx_mem
    import grev_pkg::*;
#(
    parameter int MAX_POINTS = DEF_MAX_POINTS
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_we,
    input  wire logic [$clog2(MAX_POINTS)-1:0] i_waddr,
    input  wire logic [COORD_W-1:0]            i_wx,
    input  wire logic [COORD_W-1:0]            i_wy,
    input  wire logic [$clog2(MAX_POINTS)-1:0] i_raddr,
    output logic      [COORD_W-1:0]            o_rx,
    output logic      [COORD_W-1:0]            o_ry
);

    logic [2*COORD_W-1:0] mem [MAX_POINTS];
    logic [2*COORD_W-1:0] r_rd;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            mem[i_waddr] <= {i_wy, i_wx};
        end
    end

    always_ff @(posedge i_clk) begin
        r_rd <= mem[i_raddr];
    end

    assign o_rx = r_rd[COORD_W-1:0];
    assign o_ry = r_rd[2*COORD_W-1:COORD_W];

endmodule

`default_nettype wire

>>> hw/rtl/grid_region_envelope_tracer_unit.sv
// Top level of the grid region envelope tracer: sequencer, scan datapath, ports.
//
//  channel   | dir | handshake                  | payload
//  ----------+-----+----------------------------+-----------------------------------------
//  s_axis    | in  | s_axis_tvalid/tready       | tuser mode, tdata col,row,label,index
//  m_axis    | out | m_axis_tvalid/tready       | tdata vertex_x,y,count,overflow
//  apb       | in  | psel/penable/pwrite/pready | grid_columns @0, grid_rows @4
//
//  The length of a trace is set by the grid memory's single read port, which
//  delivers one cell a cycle, plus a drain and up to two vertex writes per line.
//  Reset clears count, overflow flag and last vertex cell; the memories hold
//  garbage until written and need no clearing pass.
//  One item is in work at a time; a finished beat waits in the output register
//  while the next item is accepted, and the sequencer holds in its last state
//  until that register frees.
`default_nettype none

module grid_region_envelope_tracer_unit
    import grev_pkg::*;
#(
    parameter int MAX_COLUMNS = DEF_MAX_COLUMNS,
    parameter int MAX_ROWS    = DEF_MAX_ROWS,
    parameter int MAX_POINTS  = DEF_MAX_POINTS,
    parameter int LABEL_BITS  = DEF_LABEL_BITS
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    // slave stream
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    // [6:0] column, [13:7] row, [21:14] label, [31:22] vertex_index
    input  wire logic [31:0] s_axis_tdata,
    // [1:0] mode
    input  wire logic [1:0]  s_axis_tuser,
    // master stream
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    // [6:0] vertex_x, [13:7] vertex_y, [23:14] vertex_count, [24] overflow, [31:25] zero
    output logic      [31:0] m_axis_tdata,
    // configuration
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [2:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic      [31:0] prdata,
    output logic             pready
);

    localparam int GA_W  = $clog2(MAX_COLUMNS * MAX_ROWS);
    localparam int VA_W  = $clog2(MAX_POINTS);
    localparam int CNT_W = $clog2(MAX_POINTS + 1);
    localparam int CMP_W = (CNT_W > IDX_W) ? CNT_W : IDX_W;

    // ------------------------------------------------------------------
    // Field unpacking
    // ------------------------------------------------------------------
    logic [MODE_W-1:0]          in_mode;
    logic [COORD_W-1:0]         in_col;
    logic [COORD_W-1:0]         in_row;
    logic [LABEL_W-1:0]         in_label;
    logic [IDX_W-1:0]           in_vidx;
    logic [LABEL_BITS+LABEL_W-1:0] lab_wide;
    logic [LABEL_BITS-1:0]      in_lab;

    assign in_mode  = s_axis_tuser;
    assign in_col   = s_axis_tdata[6:0];
    assign in_row   = s_axis_tdata[13:7];
    assign in_label = s_axis_tdata[21:14];
    assign in_vidx  = s_axis_tdata[31:22];
    // Mask the label to the stored label width.
    assign lab_wide = {{LABEL_BITS{1'b0}}, in_label};
    assign in_lab   = lab_wide[LABEL_BITS-1:0];

    // ------------------------------------------------------------------
    // Configuration
    // ------------------------------------------------------------------
    logic [COORD_W-1:0] cols;
    logic [COORD_W-1:0] rows;

    grev_cfg_regs #(
        .MAX_COLUMNS(MAX_COLUMNS),
        .MAX_ROWS   (MAX_ROWS)
    ) u_cfg (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready),
        .o_grid_columns(cols),
        .o_grid_rows   (rows)
    );

    // ------------------------------------------------------------------
    // Registers
    // ------------------------------------------------------------------
    t_state              r_state, n_state;
    t_pass               r_pass;
    logic [CNT_W-1:0]    r_count;
    logic                r_ovf;
    logic [COORD_W-1:0]  r_last_col;
    logic [COORD_W-1:0]  r_last_row;
    logic                r_m_valid;
    logic [31:0]         r_m_data;

    logic [COORD_W-1:0]  r_outer;
    logic [COORD_W-1:0]  r_inner;
    logic [COORD_W-1:0]  r_pinner;
    logic                r_pv;
    logic [COORD_W-1:0]  r_hit;
    logic [LABEL_BITS-1:0] r_label;
    logic                r_rd_ok;
    logic [COORD_W-1:0]  r_res_x;
    logic [COORD_W-1:0]  r_res_y;

    // ------------------------------------------------------------------
    // Memories
    // ------------------------------------------------------------------
    logic                  grid_we;
    logic [GA_W-1:0]       grid_waddr;
    logic [GA_W-1:0]       grid_raddr;
    logic [LABEL_BITS-1:0] grid_rdata;

    logic                  vtx_we;
    logic [VA_W-1:0]       vtx_waddr;
    logic [COORD_W-1:0]    vtx_wx;
    logic [COORD_W-1:0]    vtx_wy;
    logic [VA_W-1:0]       vtx_raddr;
    logic [COORD_W-1:0]    vtx_rx;
    logic [COORD_W-1:0]    vtx_ry;

    grev_grid_mem #(
        .MAX_COLUMNS(MAX_COLUMNS),
        .MAX_ROWS   (MAX_ROWS),
        .LABEL_BITS (LABEL_BITS)
    ) u_grid (
        .i_clk  (i_clk),
        .i_we   (grid_we),
        .i_waddr(grid_waddr),
        .i_wdata(in_lab),
        .i_raddr(grid_raddr),
        .o_rdata(grid_rdata)
    );

    grev_vtx_mem #(
        .MAX_POINTS(MAX_POINTS)
    ) u_vtx (
        .i_clk  (i_clk),
        .i_we   (vtx_we),
        .i_waddr(vtx_waddr),
        .i_wx   (vtx_wx),
        .i_wy   (vtx_wy),
        .i_raddr(vtx_raddr),
        .o_rx   (vtx_rx),
        .o_ry   (vtx_ry)
    );

    // Cell (column, row), both from 1, to a flat grid address, column major.
    function automatic logic [GA_W-1:0] grid_addr(input logic [COORD_W-1:0] c,
                                                  input logic [COORD_W-1:0] r);
        logic [COORD_W-1:0] cm1;
        logic [COORD_W-1:0] rm1;
        cm1 = c - COORD_W'(1);
        rm1 = r - COORD_W'(1);
        return GA_W'(cm1) * GA_W'(MAX_ROWS) + GA_W'(rm1);
    endfunction

    // ------------------------------------------------------------------
    // Combinational datapath
    // ------------------------------------------------------------------
    logic               accept;
    logic               load_ok;
    logic [CMP_W-1:0]   idx_ext;
    logic [CMP_W-1:0]   cnt_ext;
    logic [CMP_W-1:0]   idx_m1;
    logic               read_ok;
    logic               along_col;
    logic               keep_last;
    logic               two_vtx;
    logic [COORD_W-1:0] inner_max;
    logic [COORD_W-1:0] pass_start;
    logic               pass_empty;
    logic               outer_last;
    logic               take;
    logic               vtx_room;
    logic               emitting;
    logic               out_free;
    logic [COORD_W-1:0] hit_p1;
    logic [COORD_W-1:0] outer_p1;
    logic [CNT_W+CNT_OUT_W-1:0] cnt_wide;
    t_state             adv_state;
    t_pass              pass_next;

    assign accept   = s_axis_tvalid && s_axis_tready;
    assign load_ok  = (in_col != '0) && (32'(in_col) <= 32'(MAX_COLUMNS))
                   && (in_row != '0) && (32'(in_row) <= 32'(MAX_ROWS));

    // Count never exceeds the store depth, so index <= count covers both bounds.
    assign idx_ext  = CMP_W'(in_vidx);
    assign cnt_ext  = CMP_W'(r_count);
    assign read_ok  = (in_vidx != '0) && (idx_ext <= cnt_ext);
    assign idx_m1   = idx_ext - CMP_W'(1);

    // North and south passes walk columns and scan rows; east and west the reverse.
    assign along_col = (r_pass == PASS_NORTH) || (r_pass == PASS_SOUTH);
    assign keep_last = (r_pass == PASS_NORTH) || (r_pass == PASS_EAST);
    assign two_vtx   = (r_pass == PASS_NORTH) || (r_pass == PASS_WEST);
    assign inner_max = along_col ? rows : cols;
    assign pass_next = t_pass'(r_pass + 2'd1);
    assign hit_p1    = r_hit + COORD_W'(1);
    assign outer_p1  = r_outer + COORD_W'(1);

    // Where each pass starts: north at 1, the others from the last vertex cell left by the one before.
    always_comb begin
        pass_start = COORD_W'(1);
        pass_empty = 1'b0;
        case (r_pass)
            PASS_NORTH: begin
                pass_start = COORD_W'(1);
                pass_empty = 1'b0;
            end
            PASS_EAST: begin
                pass_start = (r_last_row < rows) ? r_last_row : rows;
                pass_empty = (pass_start == '0);
            end
            PASS_SOUTH: begin
                pass_start = (r_last_col < cols) ? r_last_col : cols;
                pass_empty = (pass_start == '0);
            end
            PASS_WEST: begin
                pass_start = (r_last_row > COORD_W'(1)) ? r_last_row : COORD_W'(1);
                pass_empty = (pass_start > rows);
            end
            default: ;
        endcase
    end

    always_comb begin
        case (r_pass)
            PASS_NORTH: outer_last = (r_outer == cols);
            PASS_WEST:  outer_last = (r_outer == rows);
            default:    outer_last = (r_outer == COORD_W'(1));
        endcase
    end

    // North and east keep the last match of a line, south and west the first.
    assign take = r_pv && (grid_rdata == r_label) && (keep_last || (r_hit == '0));

    assign vtx_room = !r_ovf && (r_count < CNT_W'(MAX_POINTS));
    assign emitting = ((r_state == ST_EMIT0) && (r_hit != '0)) || (r_state == ST_EMIT1);
    assign out_free = !r_m_valid || m_axis_tready;

    // Corner coordinates of the vertex written in this emit cycle.
    always_comb begin
        vtx_wx = r_outer;
        vtx_wy = r_hit;
        case (r_pass)
            PASS_NORTH: begin
                vtx_wx = (r_state == ST_EMIT1) ? outer_p1 : r_outer;
                vtx_wy = hit_p1;
            end
            PASS_EAST: begin
                vtx_wx = hit_p1;
                vtx_wy = r_outer;
            end
            PASS_SOUTH: begin
                vtx_wx = r_outer;
                vtx_wy = r_hit;
            end
            PASS_WEST: begin
                vtx_wx = r_hit;
                vtx_wy = (r_state == ST_EMIT1) ? outer_p1 : r_outer;
            end
            default: ;
        endcase
    end

    assign adv_state = outer_last ? ((r_pass == PASS_WEST) ? ST_DONE : ST_PASS) : ST_SCAN;

    // ------------------------------------------------------------------
    // Sequencer: next state
    // ------------------------------------------------------------------
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (accept) begin
                    case (in_mode)
                        MODE_TRACE: n_state = ST_PASS;
                        MODE_READ:  n_state = ST_READ;
                        default:    n_state = ST_DONE;
                    endcase
                end
            end
            ST_READ:  n_state = ST_DONE;
            ST_PASS: begin
                if (!pass_empty) begin
                    n_state = ST_SCAN;
                end else if (r_pass == PASS_WEST) begin
                    n_state = ST_DONE;
                end
            end
            ST_SCAN: begin
                if (r_inner == inner_max) begin
                    n_state = ST_DRAIN;
                end
            end
            ST_DRAIN: n_state = ST_EMIT0;
            ST_EMIT0: n_state = ((r_hit != '0) && two_vtx) ? ST_EMIT1 : adv_state;
            ST_EMIT1: n_state = adv_state;
            ST_DONE: begin
                if (out_free) begin
                    n_state = ST_IDLE;
                end
            end
            default:  n_state = ST_IDLE;
        endcase
    end

    // ------------------------------------------------------------------
    // Sequencer: outputs to ports and memories
    // ------------------------------------------------------------------
    always_comb begin
        s_axis_tready = (r_state == ST_IDLE);
        grid_we       = accept && (in_mode == MODE_LOAD) && load_ok;
        grid_waddr    = grid_addr(in_col, in_row);
        grid_raddr    = along_col ? grid_addr(r_outer, r_inner) : grid_addr(r_inner, r_outer);
        vtx_we        = emitting && vtx_room;
        vtx_waddr     = r_count[VA_W-1:0];
        vtx_raddr     = idx_m1[VA_W-1:0];
    end

    // ------------------------------------------------------------------
    // Control registers
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= ST_IDLE;
            r_pass     <= PASS_NORTH;
            r_count    <= '0;
            r_ovf      <= 1'b0;
            r_last_col <= '0;
            r_last_row <= '0;
        end else begin
            r_state <= n_state;
            // A trace clears the store count and flag up front.
            if (accept && (in_mode == MODE_TRACE)) begin
                r_count <= '0;
                r_ovf   <= 1'b0;
                r_pass  <= PASS_NORTH;
            end
            // Skip an empty pass, or step to the next one after its last line.
            if ((r_state == ST_PASS) && pass_empty && (r_pass != PASS_WEST)) begin
                r_pass <= pass_next;
            end
            if (((r_state == ST_EMIT0) && !((r_hit != '0) && two_vtx))
                || (r_state == ST_EMIT1)) begin
                if (outer_last && (r_pass != PASS_WEST)) begin
                    r_pass <= pass_next;
                end
            end
            // Append a vertex, or drop it once the store is full.
            if (emitting) begin
                if (vtx_room) begin
                    r_count <= r_count + CNT_W'(1);
                end else begin
                    r_ovf <= 1'b1;
                end
            end
            if ((r_state == ST_EMIT0) && (r_hit != '0)) begin
                if (along_col) begin
                    r_last_col <= r_outer;
                    r_last_row <= r_hit;
                end else begin
                    r_last_col <= r_hit;
                    r_last_row <= r_outer;
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Scan and result registers
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        case (r_state)
            ST_IDLE: begin
                if (accept) begin
                    r_res_x <= '0;
                    r_res_y <= '0;
                    r_label <= in_lab;
                    r_rd_ok <= read_ok;
                end
            end
            ST_READ: begin
                r_res_x <= r_rd_ok ? vtx_rx : '0;
                r_res_y <= r_rd_ok ? vtx_ry : '0;
            end
            ST_PASS: begin
                r_pv    <= 1'b0;
                r_hit   <= '0;
                r_inner <= COORD_W'(1);
                r_outer <= pass_start;
            end
            ST_SCAN: begin
                // Issue the next cell, fold in the one that just came back.
                r_pv     <= 1'b1;
                r_pinner <= r_inner;
                r_inner  <= r_inner + COORD_W'(1);
                if (take) begin
                    r_hit <= r_pinner;
                end
            end
            ST_DRAIN: begin
                r_pv <= 1'b0;
                if (take) begin
                    r_hit <= r_pinner;
                end
            end
            ST_EMIT0, ST_EMIT1: begin
                if ((r_state == ST_EMIT1) || !((r_hit != '0) && two_vtx)) begin
                    r_inner <= COORD_W'(1);
                    r_hit   <= '0;
                    if (!outer_last) begin
                        if ((r_pass == PASS_NORTH) || (r_pass == PASS_WEST)) begin
                            r_outer <= outer_p1;
                        end else begin
                            r_outer <= r_outer - COORD_W'(1);
                        end
                    end
                end
            end
            default: ;
        endcase
    end

    // ------------------------------------------------------------------
    // Output register
    // ------------------------------------------------------------------
    assign cnt_wide = {{CNT_OUT_W{1'b0}}, r_count};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_m_valid <= 1'b0;
        end else if ((r_state == ST_DONE) && out_free) begin
            r_m_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_m_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if ((r_state == ST_DONE) && out_free) begin
            r_m_data <= {7'd0, r_ovf, cnt_wide[CNT_OUT_W-1:0], r_res_y, r_res_x};
        end
    end

    assign m_axis_tvalid = r_m_valid;
    assign m_axis_tdata  = r_m_data;

`ifndef SYNTHESIS
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(MAX_POINTS))
        else $error("vertex count beyond store depth");

    a_write_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        vtx_we |-> (!r_ovf && (r_count < CNT_W'(MAX_POINTS))))
        else $error("vertex written into a full store");

    a_ovf_when_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_ovf) |-> (r_count == CNT_W'(MAX_POINTS)))
        else $error("overflow raised before the store filled");

    a_drain_has_data: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_DRAIN) |-> r_pv)
        else $error("drain cycle without a cell in flight");

    a_scan_in_line: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_SCAN) |-> ((r_inner != '0) && (r_inner <= inner_max)))
        else $error("scan index left the line");
`endif

endmodule

`default_nettype wire
